// ===== rtl/event_channel_dispatcher_macros.svh =====
// Assertion macros shared by the event channel dispatcher RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef EVENT_CHANNEL_DISPATCHER_MACROS_SVH
`define EVENT_CHANNEL_DISPATCHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ECD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ECD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ecd_pkg.sv =====
// Shared types, constants and helper functions of the event channel dispatcher.
// Depends on nothing; used by the controller, the datapath and the top level.
package ecd_pkg;

  localparam int unsigned WordsDef       = 8;
  localparam int unsigned BitsPerWordDef = 64;
  localparam int unsigned TagWidthDef    = 32;

  localparam int unsigned OpcodeW  = 3;
  localparam int unsigned PortW    = 9;
  localparam int unsigned InTagW   = 32;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned OutUserW = 1;

  typedef enum logic [OpcodeW-1:0] {
    OP_RAISE    = 3'd0,
    OP_MASK     = 3'd1,
    OP_UNMASK   = 3'd2,
    OP_REGISTER = 3'd3,
    OP_UNREG    = 3'd4,
    OP_DISPATCH = 3'd5
  } opcode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic clr_step;
    logic word_rd;
    logic word_wr;
    logic tag_wr;
    logic take_sum;
    logic pick_rd;
    logic eval;
    logic tag_cap;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_e op;
    logic    ok;
    logic    working_empty;
    logic    summary_empty;
    logic    act_hit;
    logic    clr_done;
    logic    out_free;
  } sts_t;

  // Index of the highest set bit; zero when the vector is empty.
  function automatic logic [5:0] top_bit(input logic [63:0] v);
    logic [5:0] idx;
    idx = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        idx = 6'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/ecd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ecd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ecd_ctrl.sv =====
// Controller state machine of the event channel dispatcher.
// Depends on ecd_pkg and event_channel_dispatcher_macros.svh.
`include "event_channel_dispatcher_macros.svh"

module ecd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output ecd_pkg::cmd_t cmd_o,
  input  ecd_pkg::sts_t sts_i
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_MODIFY = 3'd3;
  localparam logic [2:0] S_PICK   = 3'd4;
  localparam logic [2:0] S_EVAL   = 3'd5;
  localparam logic [2:0] S_TAG    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       retake_q, retake_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      retake_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      retake_q <= retake_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    retake_d = retake_q;
    cmd_o    = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          retake_d      = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.op)
          ecd_pkg::OP_RAISE, ecd_pkg::OP_MASK, ecd_pkg::OP_UNMASK: begin
            if (sts_i.ok) begin
              cmd_o.word_rd = 1'b1;
              state_d       = S_MODIFY;
            end else begin
              state_d = S_DONE;
            end
          end
          ecd_pkg::OP_REGISTER, ecd_pkg::OP_UNREG: begin
            cmd_o.tag_wr = sts_i.ok;
            state_d      = S_DONE;
          end
          ecd_pkg::OP_DISPATCH: begin
            state_d = S_PICK;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_MODIFY: begin
        cmd_o.word_wr = 1'b1;
        state_d       = S_DONE;
      end
      S_PICK: begin
        if (!sts_i.working_empty) begin
          cmd_o.pick_rd = 1'b1;
          state_d       = S_EVAL;
        end else if (retake_q && !sts_i.summary_empty) begin
          // The working copy ran dry: take over the summary, once per dispatch.
          cmd_o.take_sum = 1'b1;
          retake_d       = 1'b0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.act_hit ? S_TAG : S_PICK;
      end
      S_TAG: begin
        cmd_o.tag_cap = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  `ECD_ASSERT_IMPL(a_take_when_empty, clk_i, rst_ni, cmd_o.take_sum, sts_i.working_empty, "summary taken over while working copy not empty")
  `ECD_ASSERT_IMPL(a_one_storage_cmd, clk_i, rst_ni, 1'b1, ($onehot0({cmd_o.clr_step, cmd_o.word_rd, cmd_o.word_wr, cmd_o.tag_wr, cmd_o.pick_rd, cmd_o.eval, cmd_o.take_sum})), "several storage commands at once")
  `ECD_ASSERT_NEXT(a_hit_reads_tag, clk_i, rst_ni, (state_q == S_EVAL) && sts_i.act_hit, state_q == S_TAG, "hit did not proceed to tag capture")
  `ECD_ASSERT_NEXT(a_clear_once, clk_i, rst_ni, state_q != S_CLEAR, state_q != S_CLEAR, "clearing pass re-entered")

endmodule

// ===== rtl/ecd_datapath.sv =====
// Datapath of the event channel dispatcher: bitmaps, summaries, tag table, result.
// Depends on ecd_pkg and ecd_ram.
module ecd_datapath #(
  parameter int unsigned WORDS         = ecd_pkg::WordsDef,
  parameter int unsigned BITS_PER_WORD = ecd_pkg::BitsPerWordDef,
  parameter int unsigned TAG_WIDTH     = ecd_pkg::TagWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ecd_pkg::OpcodeW-1:0]   in_op_i,
  input  logic [ecd_pkg::PortW-1:0]     in_port_i,
  input  logic [ecd_pkg::InTagW-1:0]    in_tag_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  ecd_pkg::cmd_t                 cmd_i,
  output ecd_pkg::sts_t                 sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          out_found_o,
  output logic [ecd_pkg::PortW-1:0]     out_port_o,
  output logic [ecd_pkg::InTagW-1:0]    out_tag_o,
  output logic                          out_present_o
);

  localparam int unsigned Bpw      = BITS_PER_WORD;
  localparam int unsigned WIdxW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned BIdxW    = $clog2(BITS_PER_WORD);
  localparam int unsigned NPorts   = WORDS * BITS_PER_WORD;
  localparam int unsigned AddrW    = $clog2(NPorts);
  localparam int unsigned TagKeepW =
    (TAG_WIDTH < ecd_pkg::InTagW) ? TAG_WIDTH : ecd_pkg::InTagW;
  localparam int unsigned MaxQ     = ((1 << ecd_pkg::PortW) - 1) / BITS_PER_WORD;
  localparam int unsigned QW       = $clog2(MaxQ + 2);
  localparam int unsigned PW       = ecd_pkg::PortW;

  // Accepted request.
  logic [ecd_pkg::OpcodeW-1:0] op_q;
  logic [PW-1:0]               port_q;
  logic [TagKeepW-1:0]         tag_q;
  logic [WIdxW-1:0]            w_q;
  logic [BIdxW-1:0]            b_q;
  logic                        ok_q;

  // Port number split into word and bit by stepping over word boundaries.
  logic [QW-1:0]    dec_q;
  logic [PW-1:0]    dec_base;
  logic [BIdxW-1:0] dec_b;
  logic             dec_ok;

  always_comb begin
    dec_q    = '0;
    dec_base = '0;
    for (int k = 1; k <= MaxQ; k++) begin
      if (in_port_i >= PW'(k * Bpw)) begin
        dec_q    = QW'(k);
        dec_base = PW'(k * Bpw);
      end
    end
    dec_b  = BIdxW'(in_port_i - dec_base);
    dec_ok = int'(dec_q) < WORDS;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q   <= in_op_i;
      port_q <= in_port_i;
      tag_q  <= TagKeepW'(in_tag_i);
      w_q    <= WIdxW'(dec_q);
      b_q    <= dec_b;
      ok_q   <= dec_ok;
    end
  end

  // Control state: enable, summaries, word valid flags, clear counter, output flag.
  logic             enabled_q;
  logic [WORDS-1:0] summary_q;
  logic [WORDS-1:0] working_q;
  logic [WORDS-1:0] wvld_q;
  logic [AddrW-1:0] clr_q;
  logic             out_vld_q;

  // Word store: {mask, pending} per word.
  logic               word_we, word_re;
  logic [WIdxW-1:0]   word_waddr, word_raddr;
  logic [2*Bpw-1:0]   word_wdata, word_rdata, word_eff;
  logic               rd_vld_q;
  logic [WIdxW-1:0]   scan_w_q;
  logic [WIdxW-1:0]   pick_w;
  logic [Bpw-1:0]     pend, msk, one_bit, hit_bit, act;
  logic [Bpw-1:0]     new_pend, new_msk;
  logic               sum_set, hit_any;
  logic [BIdxW-1:0]   hit_b;
  logic [AddrW-1:0]   sel_d, sel_q;

  assign pick_w   = WIdxW'(ecd_pkg::top_bit(64'(working_q)));
  assign word_eff = rd_vld_q ? word_rdata : '0;
  assign pend     = word_eff[Bpw-1:0];
  assign msk      = word_eff[2*Bpw-1:Bpw];
  assign one_bit  = {{(Bpw-1){1'b0}}, 1'b1} << b_q;
  assign act      = enabled_q ? (pend & ~msk) : '0;
  assign hit_any  = |act;
  assign hit_b    = BIdxW'(ecd_pkg::top_bit(64'(act)));
  assign hit_bit  = {{(Bpw-1){1'b0}}, 1'b1} << hit_b;
  assign sel_d    = AddrW'(AddrW'(scan_w_q) * AddrW'(Bpw)) + AddrW'(hit_b);

  always_comb begin
    new_pend = pend;
    new_msk  = msk;
    sum_set  = 1'b0;
    case (op_q)
      ecd_pkg::OP_RAISE: begin
        new_pend = pend | one_bit;
        sum_set  = 1'b1;
      end
      ecd_pkg::OP_MASK: begin
        new_msk = msk | one_bit;
      end
      ecd_pkg::OP_UNMASK: begin
        new_msk = msk & ~one_bit;
        sum_set = |(pend & one_bit);
      end
      default: begin
      end
    endcase
  end

  assign word_re    = cmd_i.word_rd | cmd_i.pick_rd;
  assign word_raddr = cmd_i.word_rd ? w_q : pick_w;
  assign word_we    = cmd_i.word_wr | (cmd_i.eval & hit_any);
  assign word_waddr = cmd_i.word_wr ? w_q : scan_w_q;
  assign word_wdata = cmd_i.word_wr ? {new_msk, new_pend}
                                    : {msk | hit_bit, pend & ~hit_bit};

  ecd_ram #(
    .WIDTH(2 * Bpw),
    .DEPTH(WORDS)
  ) u_word_ram (
    .clk_i  (clk_i),
    .we_i   (word_we),
    .waddr_i(word_waddr),
    .wdata_i(word_wdata),
    .re_i   (word_re),
    .raddr_i(word_raddr),
    .rdata_o(word_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (word_re) begin
      rd_vld_q <= wvld_q[word_raddr];
    end
    if (cmd_i.pick_rd) begin
      scan_w_q <= pick_w;
    end
    if (cmd_i.eval && hit_any) begin
      sel_q <= sel_d;
    end
  end

  // Tag table: {valid, tag} per port, cleared by a sweep after reset.
  logic                tag_we;
  logic [AddrW-1:0]    tag_waddr;
  logic [TagKeepW:0]   tag_wdata, tag_rdata;

  assign tag_we    = cmd_i.clr_step | cmd_i.tag_wr;
  assign tag_waddr = cmd_i.clr_step ? clr_q : AddrW'(port_q);
  assign tag_wdata = (cmd_i.tag_wr && (op_q == ecd_pkg::OP_REGISTER)) ?
                     {1'b1, tag_q} : '0;

  ecd_ram #(
    .WIDTH(TagKeepW + 1),
    .DEPTH(NPorts)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (tag_we),
    .waddr_i(tag_waddr),
    .wdata_i(tag_wdata),
    .re_i   (cmd_i.eval & hit_any),
    .raddr_i(sel_d),
    .rdata_o(tag_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b1;
      summary_q <= '0;
      working_q <= '0;
      wvld_q    <= '0;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        enabled_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AddrW'(1);
      end
      if (cmd_i.word_wr) begin
        wvld_q[w_q] <= 1'b1;
        if (sum_set) begin
          summary_q[w_q] <= 1'b1;
        end
      end
      if (cmd_i.take_sum) begin
        working_q <= summary_q;
        summary_q <= '0;
      end
      if (cmd_i.eval) begin
        if (hit_any) begin
          wvld_q[scan_w_q] <= 1'b1;
        end else begin
          working_q[scan_w_q] <= 1'b0;
        end
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Result staging and output register.
  logic                        res_found_q, res_present_q;
  logic [PW-1:0]               res_port_q;
  logic [ecd_pkg::InTagW-1:0]  res_tag_q;
  logic                        out_found_q, out_present_q;
  logic [PW-1:0]               out_port_q;
  logic [ecd_pkg::InTagW-1:0]  out_tag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      res_found_q   <= 1'b0;
      res_port_q    <= '0;
      res_tag_q     <= '0;
      res_present_q <= 1'b0;
    end else if (cmd_i.tag_cap) begin
      res_found_q   <= 1'b1;
      res_port_q    <= PW'(sel_q);
      res_tag_q     <= ecd_pkg::InTagW'(tag_rdata[TagKeepW-1:0]);
      res_present_q <= tag_rdata[TagKeepW];
    end
    if (cmd_i.out_load) begin
      out_found_q   <= res_found_q;
      out_port_q    <= res_port_q;
      out_tag_q     <= res_tag_q;
      out_present_q <= res_present_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_found_o   = out_found_q;
  assign out_port_o    = out_port_q;
  assign out_tag_o     = out_tag_q;
  assign out_present_o = out_present_q;

  assign sts_o.op            = ecd_pkg::opcode_e'(op_q);
  assign sts_o.ok            = ok_q;
  assign sts_o.working_empty = ~|working_q;
  assign sts_o.summary_empty = ~|summary_q;
  assign sts_o.act_hit       = hit_any;
  assign sts_o.clr_done      = (clr_q == AddrW'(NPorts - 1));
  assign sts_o.out_free      = ~out_vld_q | out_ready_i;

endmodule

// ===== rtl/event_channel_dispatcher.sv =====
// Top level of the two-level event channel dispatcher.
// Depends on ecd_pkg, ecd_ctrl, ecd_datapath and ecd_ram.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser: opcode; tdata: port, handler_tag
//   m_axis    out        tuser: found; tdata: event_port, event_tag, tag_present
//   cfg       in         one bit, all_channels_enabled, written when cfg_we_i is high
//
// Raise, mask and unmask read the word store in DECODE and write it back in MODIFY
// before DONE loads the result; tag register and unregister write the tag table.
// A dispatch reads one scanned word in PICK and evaluates it in EVAL; a word with an
// active channel goes on to tag capture in TAG, a word found empty returns to PICK,
// and an empty working copy takes over the summary at most once per dispatch.
// After reset a sweep clears the tag table, WORDS * BITS_PER_WORD entries (512 by
// default), before the first request is taken; configuration writes are taken
// throughout. A finished result waits in the output register while the next
// request is accepted and worked on; only its completion stalls on m_axis_tready_i.
module event_channel_dispatcher #(
  parameter int unsigned WORDS         = ecd_pkg::WordsDef,
  parameter int unsigned BITS_PER_WORD = ecd_pkg::BitsPerWordDef,
  parameter int unsigned TAG_WIDTH     = ecd_pkg::TagWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request channel.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [ecd_pkg::InDataW-1:0]    s_axis_tdata_i,  // port[8:0], handler_tag[40:9]
  input  logic [ecd_pkg::InUserW-1:0]    s_axis_tuser_i,  // opcode[2:0]
  // Result channel.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [ecd_pkg::OutDataW-1:0]   m_axis_tdata_o,  // event_port[8:0],
                                                          // event_tag[40:9],
                                                          // tag_present[41]
  output logic [ecd_pkg::OutUserW-1:0]   m_axis_tuser_o,  // found[0]
  // Configuration register all_channels_enabled.
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i
);

  localparam int unsigned PW = ecd_pkg::PortW;
  localparam int unsigned TW = ecd_pkg::InTagW;

  ecd_pkg::cmd_t cmd;
  ecd_pkg::sts_t sts;

  logic          out_found, out_present;
  logic [PW-1:0] out_port;
  logic [TW-1:0] out_tag;

  // The controller sequences each request; the datapath holds the bitmaps, tables and result.
  ecd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  ecd_datapath #(
    .WORDS        (WORDS),
    .BITS_PER_WORD(BITS_PER_WORD),
    .TAG_WIDTH    (TAG_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_op_i      (s_axis_tuser_i[ecd_pkg::OpcodeW-1:0]),
    .in_port_i    (s_axis_tdata_i[PW-1:0]),
    .in_tag_i     (s_axis_tdata_i[PW+TW-1:PW]),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_found_o  (out_found),
    .out_port_o   (out_port),
    .out_tag_o    (out_tag),
    .out_present_o(out_present)
  );

  // Pack the result; the unused top bits of tdata read as zero.
  assign m_axis_tdata_o = {{(ecd_pkg::OutDataW - PW - TW - 1){1'b0}},
                           out_present, out_tag, out_port};
  assign m_axis_tuser_o = out_found;

endmodule
